### rtl/core/svfp_pkg.sv
`timescale 1ns / 1ps
package svfp_pkg;

  localparam int SVID_CAP = 32;
  localparam int ID_AW    = $clog2(SVID_CAP);
  localparam int ID_CW    = $clog2(SVID_CAP + 1);
  localparam int MAX_CHARS = 31;

  localparam logic [7:0] TAG_PDU    = 8'h60;
  localparam logic [7:0] TAG_NOASDU = 8'h80;
  localparam logic [7:0] TAG_SEQ    = 8'hA2;
  localparam logic [7:0] TAG_SET    = 8'h30;
  localparam logic [7:0] TAG_ID     = 8'h80;
  localparam logic [7:0] TAG_CNT    = 8'h82;

  localparam logic [15:0] ETH_TYPE_OFF  = 16'd13;
  localparam logic [15:0] VLAN_TYPE_OFF = 16'd17;

  localparam logic [0:0] REG_SV_ETHERTYPE   = 1'b0;
  localparam logic [0:0] REG_VLAN_ETHERTYPE = 1'b1;

  typedef enum logic [2:0] {
    PH_ETH, PH_SVHDR, PH_SKIP, PH_CONTENT, PH_DONE, PH_TAG, PH_LEN, PH_LENX
  } phase_t;

  typedef enum logic [2:0] {
    LV_PDU, LV_NOASDU, LV_SEQ, LV_ASDU, LV_ELEM
  } level_t;

  typedef struct packed {
    logic             we;
    logic [ID_AW-1:0] addr;
    logic [7:0]       data;
  } id_wr_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [15:0]      app_id;
    logic [15:0]      smp_cnt;
    logic [ID_CW-1:0] id_count;
  } frame_res_t;

endpackage

### rtl/core/svfp_parser.sv
`timescale 1ns / 1ps
module svfp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_frame,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [15:0]               cfg_wdata,
  output svfp_pkg::id_wr_t          id_wr,
  output svfp_pkg::frame_res_t      res
);
  import svfp_pkg::*;

  logic [15:0] sv_type_r, vlan_type_r;
  logic [15:0] off_r, off_nxt;
  phase_t      ph_r, ph_nxt;
  level_t      lv_r, lv_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [15:0] app_r, app_nxt;
  logic [15:0] smp_r, smp_nxt;
  logic [1:0]  found_r, found_nxt;
  logic [33:0] pdu_end_r, pdu_end_nxt, seq_end_r, seq_end_nxt;
  logic [33:0] asdu_end_r, asdu_end_nxt, ee_r, ee_nxt;
  logic [ID_CW-1:0] cnt_r, cnt_nxt;
  logic        err_r, err_nxt;

  logic [33:0] off34, hdr_end, tlv_end, enc_end, svh_idx;
  logic        hdr_go, el_go;
  logic [31:0] len_val;
  logic [6:0]  nlen;
  logic [16:0] frame_bytes;

  assign off34 = {18'd0, off_r};
  assign hdr_end = off34 + 34'd1;
  assign tlv_end = hdr_end + {2'd0, len_val};
  assign svh_idx = off34 + 34'd8 - ee_r;
  assign nlen = data_byte[6:0];
  assign frame_bytes = {1'b0, off_r} + 17'd1;

  always_comb begin
    unique case (lv_r)
      LV_ASDU: enc_end = seq_end_r;
      LV_ELEM: enc_end = asdu_end_r;
      default: enc_end = pdu_end_r;
    endcase
  end

  always_comb begin
    off_nxt = off_r; ph_nxt = ph_r; lv_nxt = lv_r; tag_nxt = tag_r;
    acc_nxt = acc_r; left_nxt = left_r; ts_nxt = ts_r; app_nxt = app_r;
    smp_nxt = smp_r; found_nxt = found_r; pdu_end_nxt = pdu_end_r;
    seq_end_nxt = seq_end_r; asdu_end_nxt = asdu_end_r; ee_nxt = ee_r;
    cnt_nxt = cnt_r; err_nxt = err_r;
    hdr_go = 1'b0; el_go = 1'b0; len_val = acc_r;
    id_wr = '0;
    res = '0;

    if (!err_r) begin
      unique case (ph_r)
        PH_ETH: begin
          if (off_r >= 16'd12) begin
            ts_nxt = {ts_r[7:0], data_byte};
            if (off_r == ETH_TYPE_OFF) begin
              if (ts_nxt != vlan_type_r) begin
                if (ts_nxt != sv_type_r) err_nxt = 1'b1;
                else begin
                  ee_nxt = off34 + 34'd9;
                  ph_nxt = PH_SVHDR;
                end
              end
            end else if (off_r == VLAN_TYPE_OFF) begin
              if (ts_nxt != sv_type_r) err_nxt = 1'b1;
              else begin
                ee_nxt = off34 + 34'd9;
                ph_nxt = PH_SVHDR;
              end
            end
          end
        end
        PH_SVHDR: begin
          if (svh_idx < 34'd2) app_nxt = {app_r[7:0], data_byte};
          if (hdr_end == ee_r) begin
            ph_nxt = PH_TAG;
            lv_nxt = LV_PDU;
          end
        end
        PH_SKIP: begin
          if (hdr_end == ee_r) begin
            ph_nxt = PH_TAG;
            lv_nxt = LV_SEQ;
          end
        end
        PH_CONTENT: begin
          if (tag_r == TAG_ID) begin
            if (cnt_r < ID_CW'(SVID_CAP)) begin
              id_wr.we   = take;
              id_wr.addr = cnt_r[ID_AW-1:0];
              id_wr.data = data_byte;
              cnt_nxt    = cnt_r + 1'b1;
            end
          end else if (tag_r == TAG_CNT) begin
            smp_nxt = {smp_r[7:0], data_byte};
          end
          if (hdr_end == ee_r) el_go = 1'b1;
        end
        PH_DONE: ;
        default: begin
          if (lv_r != LV_PDU && off34 >= enc_end) err_nxt = 1'b1;
          else if (ph_r == PH_TAG) begin
            tag_nxt = data_byte;
            ph_nxt  = PH_LEN;
          end else if (ph_r == PH_LEN) begin
            if (!data_byte[7]) begin
              acc_nxt = {24'd0, data_byte};
              len_val = acc_nxt;
              hdr_go  = 1'b1;
            end else if (nlen == 7'd0 || nlen > 7'd4) begin
              err_nxt = 1'b1;
            end else begin
              left_nxt = nlen[2:0];
              acc_nxt  = '0;
              ph_nxt   = PH_LENX;
            end
          end else begin
            acc_nxt  = {acc_r[23:0], data_byte};
            left_nxt = left_r - 3'd1;
            len_val  = acc_nxt;
            hdr_go   = (left_nxt == 3'd0);
          end
        end
      endcase

      if (hdr_go) begin
        if (lv_r != LV_PDU && tlv_end > enc_end) err_nxt = 1'b1;
        else begin
          unique case (lv_r)
            LV_PDU: begin
              if (tag_r != TAG_PDU) err_nxt = 1'b1;
              else begin
                pdu_end_nxt = tlv_end;
                ph_nxt = PH_TAG; lv_nxt = LV_NOASDU;
              end
            end
            LV_NOASDU: begin
              if (tag_r != TAG_NOASDU) err_nxt = 1'b1;
              else begin
                ee_nxt = tlv_end;
                if (len_val == 32'd0) begin
                  ph_nxt = PH_TAG; lv_nxt = LV_SEQ;
                end else ph_nxt = PH_SKIP;
              end
            end
            LV_SEQ: begin
              if (tag_r != TAG_SEQ) err_nxt = 1'b1;
              else begin
                seq_end_nxt = tlv_end;
                ph_nxt = PH_TAG; lv_nxt = LV_ASDU;
              end
            end
            LV_ASDU: begin
              if (tag_r != TAG_SET || len_val == 32'd0) err_nxt = 1'b1;
              else begin
                asdu_end_nxt = tlv_end;
                ph_nxt = PH_TAG; lv_nxt = LV_ELEM;
              end
            end
            default: begin
              ee_nxt = tlv_end;
              if (tag_r == TAG_ID && len_val >= 32'(SVID_CAP)) err_nxt = 1'b1;
              else if (tag_r == TAG_CNT && len_val != 32'd2) err_nxt = 1'b1;
              else begin
                if (tag_r == TAG_ID) cnt_nxt = '0;
                if (tag_r == TAG_CNT) smp_nxt = '0;
                if (len_val == 32'd0) el_go = 1'b1;
                else ph_nxt = PH_CONTENT;
              end
            end
          endcase
        end
      end

      if (el_go) begin
        if (tag_r == TAG_ID) found_nxt[0] = 1'b1;
        else if (tag_r == TAG_CNT) found_nxt[1] = 1'b1;
        if (found_nxt == 2'b11) ph_nxt = PH_DONE;
        else if (ee_nxt >= asdu_end_r) err_nxt = 1'b1;
        else begin
          ph_nxt = PH_TAG; lv_nxt = LV_ELEM;
        end
      end
    end

    if (!end_of_frame) begin
      if (off_r == 16'hFFFF) err_nxt = 1'b1;
      else off_nxt = off_r + 16'd1;
    end else begin
      res.valid    = take;
      res.ok       = !err_nxt && ph_nxt == PH_DONE && pdu_end_nxt <= {17'd0, frame_bytes};
      res.app_id   = app_nxt;
      res.smp_cnt  = smp_nxt;
      res.id_count = cnt_nxt;
      off_nxt = '0; ph_nxt = PH_ETH; lv_nxt = LV_PDU; tag_nxt = '0; acc_nxt = '0;
      left_nxt = '0; ts_nxt = '0; app_nxt = '0; smp_nxt = '0; found_nxt = '0;
      pdu_end_nxt = '0; seq_end_nxt = '0; asdu_end_nxt = '0; ee_nxt = '0;
      cnt_nxt = '0; err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_type_r <= 16'h88BA; vlan_type_r <= 16'h8100;
      off_r <= '0; ph_r <= PH_ETH; lv_r <= LV_PDU; tag_r <= '0; acc_r <= '0;
      left_r <= '0; ts_r <= '0; app_r <= '0; smp_r <= '0; found_r <= '0;
      pdu_end_r <= '0; seq_end_r <= '0; asdu_end_r <= '0; ee_r <= '0;
      cnt_r <= '0; err_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SV_ETHERTYPE:   sv_type_r   <= cfg_wdata;
          REG_VLAN_ETHERTYPE: vlan_type_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        off_r <= off_nxt; ph_r <= ph_nxt; lv_r <= lv_nxt; tag_r <= tag_nxt;
        acc_r <= acc_nxt; left_r <= left_nxt; ts_r <= ts_nxt; app_r <= app_nxt;
        smp_r <= smp_nxt; found_r <= found_nxt; pdu_end_r <= pdu_end_nxt;
        seq_end_r <= seq_end_nxt; asdu_end_r <= asdu_end_nxt; ee_r <= ee_nxt;
        cnt_r <= cnt_nxt; err_r <= err_nxt;
      end
    end
  end

endmodule

### rtl/core/svfp_emitter.sv
`timescale 1ns / 1ps
module svfp_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svfp_pkg::id_wr_t      id_wr,
  input  svfp_pkg::frame_res_t  res,
  output logic                  busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import svfp_pkg::*;

  logic [7:0]       id_mem [SVID_CAP];
  logic             busy_r;
  logic [ID_CW-1:0] idx_r, n_r, cnt_r;
  logic             ok_r;
  logic [15:0]      app_r, smp_r;
  logic             vld_r;
  logic [47:0]      data_r;
  logic             kind_r, last_r;
  logic             slot_free;
  logic [ID_CW-1:0] n_nxt;

  assign slot_free = !vld_r || out_tready;
  assign busy = busy_r;
  assign out_tvalid = vld_r;
  assign out_tdata = data_r;
  assign out_tuser = kind_r;
  assign out_tlast = last_r;
  assign n_nxt = (res.id_count < ID_CW'(MAX_CHARS)) ? res.id_count : ID_CW'(MAX_CHARS);

  always_ff @(posedge clk) begin
    if (id_wr.we) id_mem[id_wr.addr] <= id_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (res.valid) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        n_r    <= res.ok ? n_nxt : '0;
        ok_r   <= res.ok;
        app_r  <= res.app_id;
        smp_r  <= res.smp_cnt;
        cnt_r  <= res.id_count;
      end
      if (slot_free) begin
        vld_r <= 1'b0;
        if (busy_r) begin
          vld_r <= 1'b1;
          if (idx_r < n_r) begin
            data_r <= {40'd0, id_mem[idx_r[ID_AW-1:0]]};
            kind_r <= 1'b0;
            last_r <= 1'b0;
            idx_r  <= idx_r + 1'b1;
          end else begin
            if (ok_r) data_r <= {2'd0, 1'b0, cnt_r[4:0], smp_r, app_r, 8'd0};
            else      data_r <= {2'd0, 1'b1, 45'd0};
            kind_r <= 1'b1;
            last_r <= 1'b1;
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

### rtl/core/sampled_values_frame_parser.sv
`timescale 1ns / 1ps
// Sampled values frame parser: takes one frame byte per cycle while in_tready
// is high (tlast on the final byte) and, at frame end, sends the svID characters
// (only for a frame that parsed ok) then a summary transfer with appID, smpCnt,
// svID length and status. Input is stalled from the final byte until the summary
// has been loaded into the output register; the svID buffer is read one
// character per cycle while the output does not stall.
module sampled_values_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // id_char, application_id, sample_count, id_length, parse_status
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import svfp_pkg::*;

  id_wr_t     id_wr;
  frame_res_t res;
  logic       busy;
  logic       take;

  assign in_tready = !busy;
  assign take = in_tvalid && in_tready;

  svfp_parser u_parser (
    .clk, .rst_n, .take, .data_byte(in_tdata), .end_of_frame(in_tlast),
    .cfg_we, .cfg_addr, .cfg_wdata, .id_wr, .res
  );

  svfp_emitter u_emitter (
    .clk, .rst_n, .id_wr, .res, .busy,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule
